@@ rtl/esct_pkg.sv @@
// Shared types, constants and fixed-point helpers for the sphere conduction step.
package esct_pkg;

  localparam int FX_W            = 48;
  localparam int GAIN_W          = 47;
  localparam int SPACE_STEPS_DEF = 32;
  localparam int MUL_SLICE       = 24;
  localparam int DIV_STEPS       = 24;
  localparam int CFG_IDX_W       = 3;

  typedef logic signed [FX_W-1:0] fx_t;
  typedef logic [GAIN_W-1:0]      gain_t;

  localparam fx_t FX_ONE = fx_t'(64'sd4294967296);
  localparam fx_t FX_MAX = fx_t'(64'sd140737488355327);
  localparam fx_t FX_MIN = fx_t'(-64'sd140737488355328);

  localparam logic [CFG_IDX_W-1:0] REG_MUSHY_LOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MUSHY_HIGH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_SOLID   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_MUSHY   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUTSIDE_TEMP = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_TEMP = 3'd5;

  // Magnitude of a Q16.32 value; the most negative value maps to 2^47.
  function automatic logic [FX_W-1:0] fx_mag(input fx_t v);
    fx_t n;
    n = -v;
    return v[FX_W-1] ? n : v;
  endfunction

  // Apply a sign to a magnitude and saturate into the Q16.32 range.
  function automatic fx_t clamp_mag(input logic neg, input logic [63:0] m);
    fx_t t;
    t = fx_t'(m[FX_W-1:0]);
    if (neg) begin
      if (m >= (64'd1 << (FX_W-1))) return FX_MIN;
      return -t;
    end
    if (m > 64'(FX_MAX)) return FX_MAX;
    return t;
  endfunction

  // Saturate a widened signed sum back to Q16.32.
  function automatic fx_t sat_fx(input logic signed [51:0] v);
    if (v > 52'(FX_MAX)) return FX_MAX;
    if (v < 52'(FX_MIN)) return FX_MIN;
    return v[FX_W-1:0];
  endfunction

endpackage

@@ rtl/enthalpy_sphere_cn_tridiag_step.sv @@
// Top level: Crank-Nicolson radial step on a sphere, Thomas solve, profile storage.
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+----------------------------------
//   in       | input     | in_valid / in_stall | restart
//   out      | output    | out_valid/out_stall | node_index, temperature, last_node
//   cfg      | input     | cfg_we              | cfg_index, cfg_data
//
// An item's time is set mostly by the shared divider, plus any output stalls: three
// divisions per row, next to five multiplies; a zero or overflowing pivot finishes its
// division without starting the divider.
// Synchronous reset clears control, loads register defaults and makes the profile read as
// zero until the first step writes it back; no clearing pass is needed.
// in_stall is high from the transfer of an item until its last node has left.
// A stalled result holds in the output register; the sequencer waits on it.
module enthalpy_sphere_cn_tridiag_step #(
  parameter int SPACE_STEPS = esct_pkg::SPACE_STEPS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               restart,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [5:0]                         node_index,
  output esct_pkg::fx_t                      temperature,
  output logic                               last_node,
  input  logic                               cfg_we,
  input  logic [esct_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [esct_pkg::FX_W-1:0]          cfg_data
);
  import esct_pkg::*;

  localparam int NODES = SPACE_STEPS + 1;
  localparam int AW    = $clog2(NODES);

  // sequencer states
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_PRE0   = 4'd1;
  localparam logic [3:0] ST_PRE1   = 4'd2;
  localparam logic [3:0] ST_PRE2   = 4'd3;
  localparam logic [3:0] ST_ROWRD  = 4'd4;
  localparam logic [3:0] ST_ROWLD  = 4'd5;
  localparam logic [3:0] ST_EXEC   = 4'd6;
  localparam logic [3:0] ST_WAIT   = 4'd7;
  localparam logic [3:0] ST_BKINIT = 4'd8;
  localparam logic [3:0] ST_BKRD   = 4'd9;
  localparam logic [3:0] ST_ORD    = 4'd10;
  localparam logic [3:0] ST_OLD    = 4'd11;
  localparam logic [3:0] ST_OWAIT  = 4'd12;

  // operations within one row, then the back substitution
  localparam logic [3:0] STEP_IDIV = 4'd0;  // (r + i/2) / i for the 1/i terms
  localparam logic [3:0] STEP_M_DN = 4'd1;  // dn * T[i-1]
  localparam logic [3:0] STEP_M_C  = 4'd2;  // (1-2r) * T[i]
  localparam logic [3:0] STEP_M_UP = 4'd3;  // up * T[i+1]
  localparam logic [3:0] STEP_M_MD = 4'd4;  // lower * previous upper
  localparam logic [3:0] STEP_UDIV = 4'd5;  // new upper
  localparam logic [3:0] STEP_M_WV = 4'd6;  // lower * previous work
  localparam logic [3:0] STEP_WDIV = 4'd7;  // new work
  localparam logic [3:0] STEP_BACK = 4'd8;  // back substitution

  // configuration
  fx_t   mushy_low, mushy_high, outside_temp, initial_temp;
  gain_t gain_solid, gain_mushy;

  // control
  logic [3:0]    state;
  logic [3:0]    step;
  logic [AW-1:0] row;
  logic [AW-1:0] node;
  logic          zero_prof;
  logic          use_init;

  // datapath registers
  fx_t           p0, p1, p2;
  gain_t         r;
  fx_t           dn, upv, wv, mdiag, tv, u_cur, u_prev, w_prev, w_next;
  logic signed [51:0] acc;
  logic          div_neg;
  logic [FX_W-1:0] div_md;

  // storage
  fx_t prof_mem [NODES];
  fx_t up_mem   [NODES];
  fx_t work_mem [NODES];
  fx_t prof_rd, up_rd, work_rd;
  logic [AW-1:0] prof_ra, prof_wa, work_wa;
  logic          prof_we, up_we, work_we;
  fx_t           prof_wd, work_wd;

  // shared units
  logic            mul_start, mul_done;
  fx_t             mul_a, mul_b, mul_y;
  logic            div_start, div_done;
  logic [FX_W-1:0] div_rem0, div_bits, div_den, div_quo, div_rem;

  // combinational datapath
  fx_t             pv;
  fx_t             mainv, cval;
  logic            is_div;
  fx_t             fn, fd;
  logic            fneg, fzero, fovf, fspecial;
  logic [FX_W-1:0] fmn, fmd;
  fx_t             spec_val;
  logic            rnd;
  fx_t             res;
  logic            fin;
  logic [AW-1:0]   twoh, rm;
  logic signed [51:0] adj, dn_raw;
  logic [51:0]     up_raw;
  fx_t             back_u, back_c;
  fx_t             back_w;

  esct_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .start(mul_start),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .y    (mul_y)
  );

  esct_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .rem0 (div_rem0),
    .bits (div_bits),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo),
    .rem  (div_rem)
  );

  assign in_stall = (state != ST_IDLE);

  // profile as seen by this step: zero after reset, initial_temp after a restart
  assign pv = use_init ? initial_temp : (zero_prof ? '0 : prof_rd);

  assign mainv = sat_fx(52'(FX_ONE) + $signed({4'b0, r, 1'b0}));
  assign cval  = sat_fx(52'(FX_ONE) - $signed({4'b0, r, 1'b0}));

  assign is_div = (step == STEP_IDIV) || (step == STEP_UDIV) || (step == STEP_WDIV);

  // fixed-point quotient operands, zero pivot and overflow detection
  always_comb begin
    fn       = (step == STEP_UDIV) ? -upv : tv;
    fd       = mdiag;
    fneg     = fn[FX_W-1] ^ fd[FX_W-1];
    fmn      = fx_mag(fn);
    fmd      = fx_mag(fd);
    fzero    = (fd == '0);
    fovf     = {16'd0, fmn} >= {fmd, 16'd0};
    fspecial = (step != STEP_IDIV) && (fzero || fovf);
    if (fzero) begin
      if (fn[FX_W-1])    spec_val = FX_MIN;
      else if (fn != '0) spec_val = FX_MAX;
      else               spec_val = '0;
    end else begin
      spec_val = fneg ? FX_MIN : FX_MAX;
    end
  end

  always_comb begin
    if (step == STEP_IDIV) begin
      div_rem0 = '0;
      div_bits = {1'b0, r} + FX_W'(row >> 1);
      div_den  = FX_W'(row);
    end else begin
      div_rem0 = {16'd0, fmn[FX_W-1:16]};
      div_bits = {fmn[15:0], 32'd0};
      div_den  = fmd;
    end
  end

  assign div_start = (state == ST_EXEC) && is_div && !fspecial;
  assign mul_start = (state == ST_EXEC) && !is_div;

  // the centre row ties node 0 to node 1: upper -1, right side 0
  assign back_u = (node == '0) ? -FX_ONE : up_rd;
  assign back_c = (node == '0) ? '0 : work_rd;

  always_comb begin
    case (step)
      STEP_M_DN: begin mul_a = dn;     mul_b = p0;     end
      STEP_M_C:  begin mul_a = cval;   mul_b = p1;     end
      STEP_M_UP: begin mul_a = upv;    mul_b = p2;     end
      STEP_M_MD: begin mul_a = -dn;    mul_b = u_prev; end
      STEP_M_WV: begin mul_a = -dn;    mul_b = w_prev; end
      default:   begin mul_a = back_u; mul_b = w_next; end
    endcase
  end

  // result of the operation that finishes this cycle
  assign rnd = {div_rem, 1'b0} >= {1'b0, div_md};
  always_comb begin
    if (state == ST_EXEC)  res = spec_val;
    else if (is_div)       res = clamp_mag(div_neg, {16'd0, div_quo} + 64'(rnd));
    else                   res = mul_y;
  end

  assign fin = ((state == ST_EXEC) && is_div && fspecial) ||
               ((state == ST_WAIT) && (is_div ? div_done : mul_done));

  // dn and up from one integer quotient: up = r + q, dn = r - q + correction
  always_comb begin
    twoh = {row[AW-1:1], 1'b0};
    rm   = div_rem[AW-1:0];
    if ((rm == '0) && (twoh == row)) adj = 52'sd1;
    else if (rm > twoh)              adj = -52'sd1;
    else                             adj = 52'sd0;
    dn_raw = $signed({5'b0, r}) - $signed({4'b0, div_quo}) + adj;
    up_raw = {5'b0, r} + {4'b0, div_quo};
  end

  assign back_w = sat_fx(52'(back_c) - 52'(mul_y));

  // memory ports
  always_comb begin
    if (state == ST_PRE0)      prof_ra = '0;
    else if (state == ST_PRE1) prof_ra = AW'(1);
    else                       prof_ra = row + AW'(1);
    prof_we = (state == ST_OLD);
    prof_wa = node;
    prof_wd = work_rd;
    up_we   = fin && (step == STEP_UDIV);
    work_we = 1'b0;
    work_wa = node;
    work_wd = back_w;
    if (fin && (step == STEP_WDIV)) begin
      work_we = 1'b1;
      work_wa = row;
      work_wd = res;
    end else if (state == ST_BKINIT) begin
      work_we = 1'b1;
      work_wa = AW'(SPACE_STEPS);
      work_wd = outside_temp;
    end else if (fin && (step == STEP_BACK)) begin
      work_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (prof_we) prof_mem[prof_wa] <= prof_wd;
    prof_rd <= prof_mem[prof_ra];
  end

  always_ff @(posedge clk) begin
    if (up_we) up_mem[row] <= res;
    up_rd <= up_mem[node];
  end

  always_ff @(posedge clk) begin
    if (work_we) work_mem[work_wa] <= work_wd;
    work_rd <= work_mem[node];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mushy_low    <= FX_ONE;
      mushy_high   <= FX_ONE;
      gain_solid   <= '0;
      gain_mushy   <= '0;
      outside_temp <= '0;
      initial_temp <= FX_ONE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MUSHY_LOW:    mushy_low    <= cfg_data;
        REG_MUSHY_HIGH:   mushy_high   <= cfg_data;
        REG_GAIN_SOLID:   gain_solid   <= cfg_data[GAIN_W-1:0];
        REG_GAIN_MUSHY:   gain_mushy   <= cfg_data[GAIN_W-1:0];
        REG_OUTSIDE_TEMP: outside_temp <= cfg_data;
        REG_INITIAL_TEMP: initial_temp <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= STEP_IDIV;
      row       <= AW'(1);
      node      <= '0;
      zero_prof <= 1'b1;
      use_init  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            use_init <= restart;
            row      <= AW'(1);
            u_prev   <= -FX_ONE;
            w_prev   <= '0;
            state    <= ST_PRE0;
          end
        end
        ST_PRE0: state <= ST_PRE1;
        ST_PRE1: begin
          p2    <= pv;
          state <= ST_PRE2;
        end
        ST_PRE2: begin
          p1    <= p2;
          p2    <= pv;
          state <= ST_ROWRD;
        end
        ST_ROWRD: state <= ST_ROWLD;
        ST_ROWLD: begin
          // shift the three-node window and pick this row's gain
          p0 <= p1;
          p1 <= p2;
          p2 <= pv;
          r  <= (p2 >= mushy_low && p2 <= mushy_high) ? gain_mushy : gain_solid;
          step  <= STEP_IDIV;
          state <= ST_EXEC;
        end
        ST_EXEC: begin
          div_neg <= fneg;
          div_md  <= fmd;
          if (!fin) state <= ST_WAIT;
        end
        ST_WAIT: ;
        ST_BKINIT: begin
          w_next <= outside_temp;
          node   <= AW'(SPACE_STEPS - 1);
          step   <= STEP_BACK;
          state  <= ST_BKRD;
        end
        ST_BKRD: state <= ST_EXEC;
        ST_ORD:  state <= ST_OLD;
        ST_OLD: begin
          temperature <= work_rd;
          node_index  <= 6'(node);
          last_node   <= (node == AW'(SPACE_STEPS));
          out_valid   <= 1'b1;
          state       <= ST_OWAIT;
        end
        ST_OWAIT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (node == AW'(SPACE_STEPS)) begin
              zero_prof <= 1'b0;
              use_init  <= 1'b0;
              state     <= ST_IDLE;
            end else begin
              node  <= node + AW'(1);
              state <= ST_ORD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase

      // retire the finishing operation and advance
      if (fin) begin
        case (step)
          STEP_IDIV: begin
            dn    <= dn_raw[FX_W-1:0];
            upv   <= (up_raw > 52'(FX_MAX)) ? FX_MAX : up_raw[FX_W-1:0];
            step  <= STEP_M_DN;
            state <= ST_EXEC;
          end
          STEP_M_DN: begin
            acc   <= 52'(mul_y);
            step  <= STEP_M_C;
            state <= ST_EXEC;
          end
          STEP_M_C: begin
            acc   <= acc + 52'(mul_y);
            step  <= STEP_M_UP;
            state <= ST_EXEC;
          end
          STEP_M_UP: begin
            wv    <= sat_fx(acc + 52'(mul_y));
            step  <= STEP_M_MD;
            state <= ST_EXEC;
          end
          STEP_M_MD: begin
            mdiag <= sat_fx(52'(mainv) - 52'(mul_y));
            step  <= STEP_UDIV;
            state <= ST_EXEC;
          end
          STEP_UDIV: begin
            u_cur <= res;
            step  <= STEP_M_WV;
            state <= ST_EXEC;
          end
          STEP_M_WV: begin
            tv    <= sat_fx(52'(wv) - 52'(mul_y));
            step  <= STEP_WDIV;
            state <= ST_EXEC;
          end
          STEP_WDIV: begin
            u_prev <= u_cur;
            w_prev <= res;
            if (row == AW'(SPACE_STEPS - 1)) begin
              state <= ST_BKINIT;
            end else begin
              row   <= row + AW'(1);
              state <= ST_ROWRD;
            end
          end
          default: begin
            // back substitution, inward to the centre
            w_next <= back_w;
            if (node == '0) begin
              state <= ST_ORD;
            end else begin
              node  <= node - AW'(1);
              state <= ST_BKRD;
            end
          end
        endcase
      end
    end
  end

  a_out_state: assert property (@(posedge clk) disable iff (rst)
      out_valid |-> (state == ST_OWAIT))
    else $error("result shown outside the output wait state");
  a_last_node: assert property (@(posedge clk) disable iff (rst)
      (out_valid && last_node) |-> (node_index == 6'(SPACE_STEPS)))
    else $error("last node flag on the wrong node");
  a_one_unit: assert property (@(posedge clk) disable iff (rst) !(mul_start && div_start))
    else $error("both shared units started together");
  a_accept_start: assert property (@(posedge clk) disable iff (rst)
      (in_valid && !in_stall) |=> (state == ST_PRE0))
    else $error("accepted item did not start the sequencer");

endmodule

@@ rtl/esct_mul.sv @@
// Multi-cycle Q16.32 multiplier: four 24x24 partial products, rounding and saturation.
module esct_mul (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  esct_pkg::fx_t a,
  input  esct_pkg::fx_t b,
  output logic          done,
  output esct_pkg::fx_t y
);
  import esct_pkg::*;

  logic [FX_W-1:0]      ma, mb;
  logic                 neg;
  logic                 busy;
  logic [2:0]           cnt;
  logic [2*MUL_SLICE-1:0] pp;
  logic [5:0]           pp_sh;
  logic [2*FX_W-1:0]    acc;
  logic [2*FX_W-1:0]    acc_rnd;
  logic [MUL_SLICE-1:0] pa, pb;

  assign pa      = cnt[0] ? ma[FX_W-1:MUL_SLICE] : ma[MUL_SLICE-1:0];
  assign pb      = cnt[1] ? mb[FX_W-1:MUL_SLICE] : mb[MUL_SLICE-1:0];
  assign acc_rnd = acc + (96'd1 << 31);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 3'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 3'd0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'd5) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ma  <= fx_mag(a);
      mb  <= fx_mag(b);
      neg <= a[FX_W-1] ^ b[FX_W-1];
      acc <= '0;
    end else if (busy) begin
      if (cnt < 3'd4) begin
        pp <= pa * pb;
        if (cnt[0] & cnt[1])      pp_sh <= 6'(2*MUL_SLICE);
        else if (cnt[0] | cnt[1]) pp_sh <= 6'(MUL_SLICE);
        else                      pp_sh <= 6'd0;
      end
      if (cnt >= 3'd1 && cnt <= 3'd4) begin
        acc <= acc + ({48'd0, pp} << pp_sh);
      end
      if (cnt == 3'd5) begin
        y <= clamp_mag(neg, acc_rnd[2*FX_W-1:32]);
      end
    end
  end

  a_start_busy: assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("multiplier did not go busy after start");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("multiplier done while still busy");
  a_no_restart: assert property (@(posedge clk) disable iff (rst) !(start && busy))
    else $error("multiplier restarted while busy");

endmodule

@@ rtl/esct_div.sv @@
// Restoring divider, two quotient bits per cycle, with preset partial remainder.
module esct_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [esct_pkg::FX_W-1:0]   rem0,
  input  logic [esct_pkg::FX_W-1:0]   bits,
  input  logic [esct_pkg::FX_W-1:0]   den,
  output logic                        done,
  output logic [esct_pkg::FX_W-1:0]   quo,
  output logic [esct_pkg::FX_W-1:0]   rem
);
  import esct_pkg::*;

  logic [FX_W-1:0] r, sh, q, d;
  logic [4:0]      cnt;
  logic            busy;
  logic [FX_W:0]   t1, t2;
  logic            ge1, ge2;
  logic [FX_W-1:0] r1, r2;

  always_comb begin
    t1  = {r, sh[FX_W-1]};
    ge1 = t1 >= {1'b0, d};
    r1  = ge1 ? FX_W'(t1 - {1'b0, d}) : t1[FX_W-1:0];
    t2  = {r1, sh[FX_W-2]};
    ge2 = t2 >= {1'b0, d};
    r2  = ge2 ? FX_W'(t2 - {1'b0, d}) : t2[FX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 5'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'(DIV_STEPS-1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      r  <= rem0;
      sh <= bits;
      d  <= den;
      q  <= '0;
    end else if (busy) begin
      r  <= r2;
      sh <= sh << 2;
      q  <= {q[FX_W-3:0], ge1, ge2};
    end
  end

  assign quo = q;
  assign rem = r;

  a_start_busy: assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("divider did not go busy after start");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while still busy");
  a_rem_bound: assert property (@(posedge clk) disable iff (rst) (busy && !start) |=> r < d)
    else $error("divider partial remainder out of range");

endmodule
